// ===== hdl/frns_pkg.sv =====
`default_nettype none

package frns_pkg;

    // Field widths fixed by the item formats.
    localparam int ID_W     = 16;
    localparam int POS_W    = 16;
    localparam int BAT_W    = 10;
    localparam int DIST_W   = 17;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CONNECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CONNECTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEIGHBOR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd7;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_BATTERY = 1'b1;
    localparam logic [DIST_W-1:0]    SEARCH_LIMIT_RST = 17'd10000;
    localparam logic [BAT_W-1:0]     INIT_BATTERY_RST = 10'd100;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ID_W-1:0]         unit_id;
        logic signed [POS_W-1:0] pos_x_in;
        logic signed [POS_W-1:0] pos_y_in;
        logic [BAT_W-1:0]        battery_in;
        logic                    alpha_tag;
    } t_frns_in;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [POS_W-1:0] pos_x_out;
        logic signed [POS_W-1:0] pos_y_out;
        logic [BAT_W-1:0]        battery_out;
        logic [ID_W-1:0]         neighbor_id;
        logic [DIST_W-1:0]       neighbor_distance;
    } t_frns_out;

    // One table entry as stored in the registry memory.
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [BAT_W-1:0]        battery;
        logic                    alpha;
        logic                    busy;
    } t_frns_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_frns_state;

endpackage

`default_nettype wire

// ===== hdl/frns_mem.sv =====
`default_nettype none

module frns_mem
    import frns_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic        i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_frns_entry      o_rd_data,
    input  wire logic        i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_frns_entry i_wr_data
);

    t_frns_entry r_mem [DEPTH];
    t_frns_entry r_rd_data;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/frns_ctrl.sv =====
`default_nettype none

module frns_ctrl
    import frns_pkg::*;
#(
    parameter int FLEET_SIZE = 16,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire t_frns_in          i_item,
    input  wire logic [DIST_W-1:0] i_search_limit,
    input  wire logic [BAT_W-1:0]  i_init_battery,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_frns_out              o_res,
    output logic [AW-1:0]          o_rd_addr,
    input  wire t_frns_entry       i_rd_data,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output t_frns_entry            o_wr_data
);

    t_frns_state       r_state, n_state;
    t_frns_in          r_item, n_item;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    t_frns_entry       r_hit, n_hit;
    logic [DIST_W-1:0] r_best, n_best;
    logic [ID_W-1:0]   r_nid, n_nid;

    logic signed [POS_W:0] w_dx, w_dy, w_ndx, w_ndy;
    logic [POS_W-1:0]      w_abs_x, w_abs_y;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_last;

    // Manhattan distance from the query point to the entry being read.
    always_comb begin
        w_dx    = {r_item.pos_x_in[POS_W-1], r_item.pos_x_in}
                - {i_rd_data.pos_x[POS_W-1], i_rd_data.pos_x};
        w_dy    = {r_item.pos_y_in[POS_W-1], r_item.pos_y_in}
                - {i_rd_data.pos_y[POS_W-1], i_rd_data.pos_y};
        w_ndx   = -w_dx;
        w_ndy   = -w_dy;
        w_abs_x = w_dx[POS_W] ? w_ndx[POS_W-1:0] : w_dx[POS_W-1:0];
        w_abs_y = w_dy[POS_W] ? w_ndy[POS_W-1:0] : w_dy[POS_W-1:0];
        w_dist  = {1'b0, w_abs_x} + {1'b0, w_abs_y};
        w_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    end

    // State and item registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        r_hit     <= n_hit;
        r_best    <= n_best;
        r_nid     <= n_nid;
    end

    // Sequencer: scan entries one per cycle, then write back and post the result.
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_count   = r_count;
        n_idx     = r_idx;
        n_found   = r_found;
        n_hit_idx = r_hit_idx;
        n_hit     = r_hit;
        n_best    = r_best;
        n_nid     = r_nid;

        o_item_ready = 1'b0;
        o_rd_addr    = AW'(r_idx + AW'(1));
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_hit_idx;
        o_wr_data    = r_hit;

        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                o_rd_addr    = '0;
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_best  = i_search_limit;
                    n_nid   = '0;
                    n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN: begin
                if (r_item.kind == KIND_NEAREST) begin
                    // Strictly smaller keeps the lowest entry on a tie.
                    if (i_rd_data.id != r_item.unit_id && w_dist < r_best) begin
                        n_best  = w_dist;
                        n_nid   = i_rd_data.id;
                        n_found = 1'b1;
                    end
                    if (w_last) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_idx = AW'(r_idx + AW'(1));
                    end
                end else if (i_rd_data.id == r_item.unit_id) begin
                    // The first match is the lowest entry with this id.
                    n_found   = 1'b1;
                    n_hit_idx = r_idx;
                    n_hit     = i_rd_data;
                    n_state   = S_DECIDE;
                end else if (w_last) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = AW'(r_idx + AW'(1));
                end
            end

            S_DECIDE: begin
                o_res_valid = 1'b1;
                case (r_item.kind)
                    KIND_CONNECT: begin
                        if (r_found && r_hit.busy) begin
                            o_res.status = ST_DUPLICATE;
                        end else if (r_found) begin
                            o_res.status      = ST_CONNECTED;
                            o_res.pos_x_out   = r_hit.pos_x;
                            o_res.pos_y_out   = r_hit.pos_y;
                            o_res.battery_out = r_hit.battery;
                            o_wr_data.busy    = 1'b1;
                            o_wr_en           = i_res_ready;
                        end else if (r_count < CW'(FLEET_SIZE)) begin
                            // New unit goes to the next free entry at the origin.
                            o_res.status      = ST_CONNECTED;
                            o_res.battery_out = i_init_battery;
                            o_wr_addr         = r_count[AW-1:0];
                            o_wr_data.id      = r_item.unit_id;
                            o_wr_data.pos_x   = '0;
                            o_wr_data.pos_y   = '0;
                            o_wr_data.battery = i_init_battery;
                            o_wr_data.alpha   = r_item.alpha_tag;
                            o_wr_data.busy    = 1'b1;
                            o_wr_en           = i_res_ready;
                            if (i_res_ready) begin
                                n_count = r_count + CW'(1);
                            end
                        end else begin
                            o_res.status = ST_FULL;
                        end
                    end
                    KIND_TRACK: begin
                        if (r_found) begin
                            o_res.status      = ST_UPDATED;
                            o_wr_data.pos_x   = r_item.pos_x_in;
                            o_wr_data.pos_y   = r_item.pos_y_in;
                            o_wr_data.battery = r_item.battery_in;
                            o_wr_data.busy    = 1'b1;
                            o_wr_en           = i_res_ready;
                        end else begin
                            o_res.status = ST_NOT_FOUND;
                        end
                    end
                    KIND_NEAREST: begin
                        if (r_found) begin
                            o_res.status            = ST_NEIGHBOR;
                            o_res.neighbor_id       = r_nid;
                            o_res.neighbor_distance = r_best;
                        end else begin
                            o_res.status = ST_NONE;
                        end
                    end
                    KIND_RELEASE: begin
                        if (r_found) begin
                            o_res.status   = ST_RELEASED;
                            o_wr_data.busy = 1'b0;
                            o_wr_en        = i_res_ready;
                        end else begin
                            o_res.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        o_res.status = ST_NOT_FOUND;
                    end
                endcase
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FLEET_SIZE))
        else $error("entry count exceeds table size");

    // Memory writes only happen while the result is handed over.
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_DECIDE) && i_res_ready)
        else $error("table write outside write-back");

    // The count only grows by one, and only on a connect.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)) && ($past(r_item.kind) == KIND_CONNECT))
        else $error("entry count changed unexpectedly");

    // The scan never reads past the filled part of the table.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("scan index beyond filled entries");
`endif

endmodule

`default_nettype wire

// ===== hdl/fleet_registry_nearest_search_top.sv =====
`default_nettype none

// Fleet registry with nearest-unit search.
// Input items (connect, track, nearest, release) arrive on i_in_valid/o_in_ready
// as a t_frns_in struct; each produces exactly one t_frns_out result on
// o_out_valid/i_out_ready. A transfer happens when valid and ready are both high.
// The table lives in a single-port-read, single-port-write memory. Each item
// scans the filled entries one per cycle (one memory read per cycle), a lookup
// stopping at its first match, then moves to write-back, where it posts its
// result and writes back the entry that it changes. A new item can be taken
// the cycle after write-back, so the block does not take a new item before
// it is through with the last one. The write-back completes before the next
// item is taken, so reads never see stale entries.
// The output register lets the next item be taken while a result waits; if the
// receiver stalls, the following item holds in write-back until the register
// frees up. Configuration writes (index 0 search limit, 1 initial battery) are
// always ready. Synchronous reset empties the table (fill count zero), restores
// the configuration defaults and drops any pending result.
module fleet_registry_nearest_search_top
    import frns_pkg::*;
#(
    parameter int FLEET_SIZE = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_frns_in             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_frns_out                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIST_W-1:0]    i_cfg_data
);

    localparam int AW = (FLEET_SIZE > 1) ? $clog2(FLEET_SIZE) : 1;
    localparam int CW = $clog2(FLEET_SIZE + 1);

    logic [DIST_W-1:0] r_search_limit;
    logic [BAT_W-1:0]  r_init_battery;
    logic              r_out_valid;
    t_frns_out         r_out_data;

    logic        w_res_valid;
    logic        w_res_ready;
    t_frns_out   w_res;
    logic [AW-1:0] w_rd_addr;
    t_frns_entry w_rd_data;
    logic        w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_frns_entry w_wr_data;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_limit <= SEARCH_LIMIT_RST;
            r_init_battery <= INIT_BATTERY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEARCH_LIMIT: r_search_limit <= i_cfg_data;
                CFG_INIT_BATTERY: r_init_battery <= i_cfg_data[BAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: loads when empty or being drained in the same cycle.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    frns_ctrl #(
        .FLEET_SIZE (FLEET_SIZE),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_in_valid),
        .o_item_ready   (o_in_ready),
        .i_item         (i_in_data),
        .i_search_limit (r_search_limit),
        .i_init_battery (r_init_battery),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data)
    );

    frns_mem #(
        .DEPTH (FLEET_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frns_pkg::*;

    localparam int FLEET_SIZE  = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    // Block ports.
    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    t_frns_in        i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_frns_out       o_out_data;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIST_W-1:0]    i_cfg_data  = '0;

    // Stimulus and result bookkeeping.
    t_frns_in        outgoing_items[$];
    t_frns_out       pending_replies[$];
    logic [ID_W-1:0] roster[$];
    int              items_queued   = 0;
    int              items_accepted = 0;
    int              results_seen   = 0;
    int              fault_count    = 0;
    int              cycle_count    = 0;
    logic            in_taken       = 1'b0;
    logic            cfg_taken      = 1'b0;

    // Idle control for both sides.
    int send_wait   = 0;
    int send_steady = 0;
    int recv_wait   = 0;
    int recv_steady = 0;

    // Shadow copy of the registry table and its registers.
    logic [ID_W-1:0]         fleet_ids  [FLEET_SIZE];
    logic signed [POS_W-1:0] fleet_x    [FLEET_SIZE];
    logic signed [POS_W-1:0] fleet_y    [FLEET_SIZE];
    logic [BAT_W-1:0]        fleet_bat  [FLEET_SIZE];
    logic                    fleet_busy [FLEET_SIZE];
    int                      fleet_fill = 0;
    logic [DIST_W-1:0]       limit_reg  = SEARCH_LIMIT_RST;
    logic [BAT_W-1:0]        start_bat_reg = INIT_BATTERY_RST;

    fleet_registry_nearest_search_top #(
        .FLEET_SIZE (FLEET_SIZE)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one item to the shadow table and returns the result it yields.
    function automatic t_frns_out registry_step(t_frns_in item);
        t_frns_out res;
        int        slot;
        int        best;
        int        span;
        int        qx;
        int        qy;
        int        px;
        int        py;
        logic      found;
        res   = '0;
        slot  = -1;
        found = 1'b0;
        qx    = item.pos_x_in;
        qy    = item.pos_y_in;
        // A lookup takes the lowest filled entry with a matching id.
        for (int k = 0; k < fleet_fill; k++) begin
            if (slot < 0 && fleet_ids[k] == item.unit_id) begin
                slot = k;
            end
        end
        case (item.kind)
            KIND_CONNECT: begin
                if (slot >= 0 && fleet_busy[slot]) begin
                    res.status = ST_DUPLICATE;
                end else begin
                    // An unknown unit joins at the origin when there is room.
                    if (slot < 0 && fleet_fill < FLEET_SIZE) begin
                        slot             = fleet_fill;
                        fleet_fill       = fleet_fill + 1;
                        fleet_ids[slot]  = item.unit_id;
                        fleet_x[slot]    = '0;
                        fleet_y[slot]    = '0;
                        fleet_bat[slot]  = start_bat_reg;
                        fleet_busy[slot] = 1'b0;
                    end
                    if (slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        fleet_busy[slot] = 1'b1;
                        res.status       = ST_CONNECTED;
                        res.pos_x_out    = fleet_x[slot];
                        res.pos_y_out    = fleet_y[slot];
                        res.battery_out  = fleet_bat[slot];
                    end
                end
            end
            KIND_TRACK: begin
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    fleet_x[slot]    = item.pos_x_in;
                    fleet_y[slot]    = item.pos_y_in;
                    fleet_bat[slot]  = item.battery_in;
                    fleet_busy[slot] = 1'b1;
                    res.status       = ST_UPDATED;
                end
            end
            KIND_NEAREST: begin
                // Strictly closer wins, so a tie keeps the earlier entry.
                best = limit_reg;
                for (int k = 0; k < fleet_fill; k++) begin
                    if (fleet_ids[k] != item.unit_id) begin
                        px   = fleet_x[k];
                        py   = fleet_y[k];
                        span = ((qx > px) ? qx - px : px - qx) + ((qy > py) ? qy - py : py - qy);
                        if (span < best) begin
                            best            = span;
                            res.neighbor_id = fleet_ids[k];
                            found           = 1'b1;
                        end
                    end
                end
                if (found) begin
                    res.status            = ST_NEIGHBOR;
                    res.neighbor_distance = best[DIST_W-1:0];
                end else begin
                    res.status = ST_NONE;
                end
            end
            KIND_RELEASE: begin
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    fleet_busy[slot] = 1'b0;
                    res.status       = ST_RELEASED;
                end
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Coordinates: a small area for real neighbors, a coarse grid for ties,
    // the corners of the range and the full range.
    function automatic logic signed [POS_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return POS_W'($urandom_range(0, 4000) - 2000);
        end else if (r < 65) begin
            return POS_W'(100 * ($urandom_range(0, 4) - 2));
        end else if (r < 68) begin
            return 16'h8000;
        end else if (r < 71) begin
            return 16'h7FFF;
        end
        return POS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [BAT_W-1:0] pick_battery();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end
        return BAT_W'($urandom_range(0, 1023));
    endfunction

    task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                              input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic [BAT_W-1:0] bat, input logic alpha);
        t_frns_in item;
        item.kind       = kind;
        item.unit_id    = id;
        item.pos_x_in   = x;
        item.pos_y_in   = y;
        item.battery_in = bat;
        item.alpha_tag  = alpha;
        outgoing_items.push_back(item);
        items_queued = items_queued + 1;
    endtask

    // Waits until every item has been taken and answered, then lets the
    // block finish its write-back.
    task automatic wait_idle();
        while (items_accepted != items_queued || pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (FLEET_SIZE + 4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_idle();
        i_cfg_index <= idx;
        i_cfg_data  <= value[DIST_W-1:0];
        i_cfg_valid <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // One phase of random traffic under a given register setting. Most items
    // address units on the roster; a few new units join, and the rest use
    // unknown ids.
    task automatic run_phase(input int unsigned limit, input int unsigned start_bat,
                             input int count);
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic              known;
        logic              joining;
        int                r;
        write_register(CFG_SEARCH_LIMIT, limit);
        write_register(CFG_INIT_BATTERY, start_bat);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                kind = KIND_CONNECT;
            end else if (r < 50) begin
                kind = KIND_TRACK;
            end else if (r < 80) begin
                kind = KIND_NEAREST;
            end else begin
                kind = KIND_RELEASE;
            end
            joining = (n % 120 == 3) && (roster.size() < FLEET_SIZE);
            if (joining || $urandom_range(0, 99) < 15) begin
                do begin
                    id    = ID_W'($urandom_range(0, 65535));
                    known = 1'b0;
                    foreach (roster[k]) begin
                        if (roster[k] == id) begin
                            known = 1'b1;
                        end
                    end
                end while (known);
                if (joining) begin
                    kind = KIND_CONNECT;
                    roster.push_back(id);
                end else if (kind == KIND_CONNECT && roster.size() < FLEET_SIZE) begin
                    // Keep the table for planned joins until it is meant to fill.
                    kind = KIND_TRACK;
                end
            end else begin
                id = roster[$urandom_range(0, roster.size() - 1)];
            end
            queue_item(kind, id, pick_coord(), pick_coord(), pick_battery(),
                       1'($urandom_range(0, 1)));
        end
    endtask

    // Main sequence.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks under the reset register values.
        queue_item(KIND_NEAREST, 16'h0005, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_TRACK,   16'h0000, 16'sd5, 16'sd5, 10'd7, 1'b0);
        queue_item(KIND_RELEASE, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_CONNECT, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b1);
        queue_item(KIND_CONNECT, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_CONNECT, 16'hFFFF, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_NEAREST, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_NEAREST, 16'h1234, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_TRACK,   16'h0000, 16'h7FFF, 16'h7FFF, 10'd1023, 1'b0);
        queue_item(KIND_TRACK,   16'hFFFF, 16'h8000, 16'h8000, 10'd0, 1'b1);
        queue_item(KIND_NEAREST, 16'h1234, 16'h8000, 16'h7FFF, 10'd0, 1'b0);
        queue_item(KIND_RELEASE, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_RELEASE, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_CONNECT, 16'h0000, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_RELEASE, 16'hFFFF, 16'sd0, 16'sd0, 10'd0, 1'b0);
        queue_item(KIND_TRACK,   16'hFFFF, 16'h8000, 16'h8000, 10'h2AA, 1'b0);
        queue_item(KIND_CONNECT, 16'hFFFF, 16'sd0, 16'sd0, 10'd0, 1'b0);

        // A zero limit hides every neighbor.
        write_register(CFG_SEARCH_LIMIT, 0);
        queue_item(KIND_NEAREST, 16'h1234, 16'h7FFF, 16'h7FFF, 10'd0, 1'b0);

        // The widest limit reaches across the whole plane.
        write_register(CFG_SEARCH_LIMIT, 131071);
        write_register(CFG_INIT_BATTERY, 1023);
        queue_item(KIND_NEAREST, 16'hFFFF, 16'h8000, 16'h8000, 10'd0, 1'b0);
        queue_item(KIND_CONNECT, 16'h8001, 16'sd0, 16'sd0, 10'd0, 1'b1);
        queue_item(KIND_NEAREST, 16'h5555, 16'sd0, 16'sd0, 10'd0, 1'b0);
        roster.push_back(16'h0000);
        roster.push_back(16'hFFFF);
        roster.push_back(16'h8001);

        // Random traffic across several register settings.
        run_phase(10000, 100, 241);
        run_phase(0, 1023, 241);
        run_phase(131071, 0, 241);
        run_phase(1, $urandom_range(0, 1023), 241);
        run_phase($urandom_range(0, 131071), $urandom_range(0, 1023), 241);
        run_phase($urandom_range(100, 5000), $urandom_range(0, 1023), 241);
        run_phase(131070, 1, 241);
        run_phase($urandom_range(0, 131071), 512, 241);

        wait_idle();
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Input driver: holds each item until its transfer, then idles at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_wait > 0) begin
                send_wait = send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (outgoing_items.size() > 0) begin
                i_in_data  <= outgoing_items.pop_front();
                i_in_valid <= 1'b1;
                if (send_steady > 0) begin
                    send_steady = send_steady - 1;
                end else if ($urandom_range(0, 99) < 4) begin
                    send_steady = $urandom_range(20, 80);
                end
                send_wait = (send_steady > 0) ? 0 : idle_length();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls with runs of steady readiness.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait = recv_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (recv_steady > 0) begin
                recv_steady = recv_steady - 1;
            end else if ($urandom_range(0, 99) < 4) begin
                recv_steady = $urandom_range(20, 80);
            end
            recv_wait = (recv_steady > 0) ? 0 : idle_length();
        end
    end

    // Monitor: tracks every transfer, predicts on input and checks on output.
    always @(posedge i_clk) begin : monitor
        t_frns_out want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SEARCH_LIMIT) begin
                    limit_reg = i_cfg_data;
                end else begin
                    start_bat_reg = i_cfg_data[BAT_W-1:0];
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_replies.push_back(registry_step(i_in_data));
                items_accepted = items_accepted + 1;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen = results_seen + 1;
                if (pending_replies.size() == 0) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_MAX) begin
                        $display("result %0d: no result was due, got status %0d",
                                 results_seen, o_out_data.status);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    if (o_out_data.status !== want.status
                        || o_out_data.pos_x_out !== want.pos_x_out
                        || o_out_data.pos_y_out !== want.pos_y_out
                        || o_out_data.battery_out !== want.battery_out
                        || o_out_data.neighbor_id !== want.neighbor_id
                        || o_out_data.neighbor_distance !== want.neighbor_distance) begin
                        fault_count = fault_count + 1;
                        if (fault_count <= REPORT_MAX) begin
                            $display("result %0d: expected st %0d x %0d y %0d bat %0d nb %h d %0d",
                                     results_seen, want.status, want.pos_x_out,
                                     want.pos_y_out, want.battery_out, want.neighbor_id,
                                     want.neighbor_distance);
                            $display("result %0d: actual   st %0d x %0d y %0d bat %0d nb %h d %0d",
                                     results_seen, o_out_data.status, o_out_data.pos_x_out,
                                     o_out_data.pos_y_out, o_out_data.battery_out,
                                     o_out_data.neighbor_id, o_out_data.neighbor_distance);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
